// File: design/pls_pkg.sv
// Shared types and constants for the positional list store.
// Holds the request and status codes and the command record passed from
// the front end through the command queue to the back end.
package pls_pkg;

    localparam int VALUE_W     = 32;
    localparam int POS_W       = 8;
    localparam int INDEX_W     = 6;
    localparam int COUNT_W     = 7;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_UPDATE = 2'd1,
        OP_DELETE = 2'd2,
        OP_DUMP   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADPOS = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    typedef struct packed {
        t_op                        op;
        t_status                    status;
        logic [POS_W-1:0]           position;
        logic signed [VALUE_W-1:0]  value;
    } t_cmd;

endpackage

// File: design/pls_front.sv
// Front end: accepts request transactions, checks them against its own
// copy of the list count and turns them into queue commands.
// Depends on pls_pkg.
module pls_front #(
    parameter int DEPTH = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [1:0]                        i_req_type,
    input  logic [pls_pkg::POS_W-1:0]         i_position,
    input  logic signed [pls_pkg::VALUE_W-1:0] i_value,
    input  logic                              i_q_full,
    output logic                              o_push,
    output pls_pkg::t_cmd                     o_cmd,
    output logic [$clog2(DEPTH+1)-1:0]        o_count
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > pls_pkg::POS_W) ? CW : pls_pkg::POS_W;

    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic [PW-1:0]    pos_x;
    logic [PW-1:0]    cnt_x;
    pls_pkg::t_op     op;
    pls_pkg::t_status status;

    assign op    = pls_pkg::t_op'(i_req_type);
    assign pos_x = PW'(i_position);
    assign cnt_x = PW'(r_count);

    always_comb begin
        status = pls_pkg::ST_OK;
        case (op)
            pls_pkg::OP_INSERT: begin
                if (r_count == CW'(DEPTH)) begin
                    status = pls_pkg::ST_FULL;
                end else if (pos_x > cnt_x) begin
                    status = pls_pkg::ST_BADPOS;
                end
            end
            pls_pkg::OP_UPDATE, pls_pkg::OP_DELETE: begin
                if (pos_x >= cnt_x) begin
                    status = pls_pkg::ST_BADPOS;
                end
            end
            pls_pkg::OP_DUMP: begin
                if (r_count == '0) begin
                    status = pls_pkg::ST_EMPTY;
                end
            end
            default: status = pls_pkg::ST_OK;
        endcase
    end

    assign o_push = i_valid && !i_q_full;

    always_comb begin
        n_count = r_count;
        if (o_push && status == pls_pkg::ST_OK) begin
            if (op == pls_pkg::OP_INSERT) begin
                n_count = r_count + CW'(1);
            end else if (op == pls_pkg::OP_DELETE) begin
                n_count = r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_cmd.op       = op;
    assign o_cmd.status   = status;
    assign o_cmd.position = i_position;
    assign o_cmd.value    = i_value;
    assign o_count        = r_count;

endmodule

// File: design/pls_queue.sv
// Short command queue between front end and back end.
// Depends on pls_pkg.
module pls_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pls_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output pls_pkg::t_cmd o_cmd
);

    localparam int QD = pls_pkg::QUEUE_DEPTH;
    localparam int QA = $clog2(QD);
    localparam int QC = $clog2(QD + 1);

    pls_pkg::t_cmd r_mem [QD];
    logic [QA-1:0] r_wr;
    logic [QA-1:0] r_rd;
    logic [QC-1:0] r_fill;
    logic          do_pop;

    assign o_full  = (r_fill == QC'(QD));
    assign o_valid = (r_fill != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QA'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QA'(1);
            end
            if (i_push && !do_pop) begin
                r_fill <= r_fill + QC'(1);
            end else if (do_pop && !i_push) begin
                r_fill <= r_fill - QC'(1);
            end
        end
    end

endmodule

// File: design/pls_back.sv
// Back end: entry memory, shift/dump sequencer and output register.
// Executes queued commands one at a time. Depends on pls_pkg.
module pls_back #(
    parameter int DEPTH = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_q_valid,
    input  pls_pkg::t_cmd                      i_q_cmd,
    output logic                               o_q_pop,
    output logic                               o_idle,
    output logic [$clog2(DEPTH+1)-1:0]         o_count,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [1:0]                         o_status,
    output logic signed [pls_pkg::VALUE_W-1:0] o_entry_value,
    output logic [pls_pkg::INDEX_W-1:0]        o_entry_index,
    output logic [pls_pkg::COUNT_W-1:0]        o_entry_count,
    output logic                               o_last
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > pls_pkg::POS_W) ? CW : pls_pkg::POS_W;
    localparam int IW = (AW > pls_pkg::INDEX_W) ? AW : pls_pkg::INDEX_W;
    localparam int KW = (CW > pls_pkg::COUNT_W) ? CW : pls_pkg::COUNT_W;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SHIFT  = 4'b0010,
        S_DUMP   = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    logic signed [pls_pkg::VALUE_W-1:0] mem [DEPTH];
    logic signed [pls_pkg::VALUE_W-1:0] r_rdata;

    t_state        r_state, n_state;
    logic [AW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_count, n_count;
    pls_pkg::t_cmd r_cmd, n_cmd;

    logic                               wr_en;
    logic [AW-1:0]                      wr_addr;
    logic signed [pls_pkg::VALUE_W-1:0] wr_data;

    logic                               slot_free;
    logic                               emit;
    pls_pkg::t_status                   e_status;
    logic signed [pls_pkg::VALUE_W-1:0] e_value;
    logic [AW-1:0]                      e_index;
    logic                               e_last;

    logic                               r_out_valid;
    pls_pkg::t_status                   r_status;
    logic signed [pls_pkg::VALUE_W-1:0] r_value;
    logic [pls_pkg::INDEX_W-1:0]        r_index;
    logic [pls_pkg::COUNT_W-1:0]        r_count_o;
    logic                               r_last;

    logic [PW-1:0] hd_pos_x;
    logic [AW-1:0] hd_pos_a;
    logic [PW-1:0] cur_pos_x;
    logic [AW-1:0] cur_pos_a;
    logic [IW-1:0] idx_x;
    logic [KW-1:0] cnt_x;

    assign hd_pos_x  = PW'(i_q_cmd.position);
    assign hd_pos_a  = hd_pos_x[AW-1:0];
    assign cur_pos_x = PW'(r_cmd.position);
    assign cur_pos_a = cur_pos_x[AW-1:0];
    assign slot_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_count  = r_count;
        n_cmd    = r_cmd;
        o_q_pop  = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = cur_pos_a;
        wr_data  = r_cmd.value;
        emit     = 1'b0;
        e_status = r_cmd.status;
        e_value  = '0;
        e_index  = '0;
        e_last   = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_cmd;
                    n_state = S_FINISH;
                    if (i_q_cmd.status == pls_pkg::ST_OK) begin
                        case (i_q_cmd.op)
                            pls_pkg::OP_INSERT: begin
                                n_count = r_count + CW'(1);
                                if (hd_pos_x != PW'(r_count)) begin
                                    n_idx   = AW'(r_count - CW'(1));
                                    n_state = S_SHIFT;
                                end
                            end
                            pls_pkg::OP_DELETE: begin
                                n_count = r_count - CW'(1);
                                if (hd_pos_x < PW'(n_count)) begin
                                    n_idx   = hd_pos_a + AW'(1);
                                    n_state = S_SHIFT;
                                end
                            end
                            pls_pkg::OP_DUMP: begin
                                n_idx   = '0;
                                n_state = S_DUMP;
                            end
                            default: n_state = S_FINISH;
                        endcase
                    end
                end
            end
            S_SHIFT: begin
                wr_en   = 1'b1;
                wr_data = r_rdata;
                if (r_cmd.op == pls_pkg::OP_INSERT) begin
                    wr_addr = r_idx + AW'(1);
                    if (r_idx == cur_pos_a) begin
                        n_state = S_FINISH;
                    end else begin
                        n_idx = r_idx - AW'(1);
                    end
                end else begin
                    wr_addr = r_idx - AW'(1);
                    if (CW'(r_idx) == r_count) begin
                        n_state = S_FINISH;
                    end else begin
                        n_idx = r_idx + AW'(1);
                    end
                end
            end
            S_DUMP: begin
                if (slot_free) begin
                    emit     = 1'b1;
                    e_status = pls_pkg::ST_OK;
                    e_value  = r_rdata;
                    e_index  = r_idx;
                    e_last   = (CW'(r_idx) + CW'(1) == r_count);
                    if (e_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + AW'(1);
                    end
                end
            end
            S_FINISH: begin
                wr_en = (r_cmd.status == pls_pkg::ST_OK) &&
                        (r_cmd.op == pls_pkg::OP_INSERT || r_cmd.op == pls_pkg::OP_UPDATE);
                if (slot_free) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // read address follows the next index so r_rdata holds mem[r_idx] as read before that cycle's write
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[n_idx];
    end

    assign idx_x = IW'(e_index);
    assign cnt_x = KW'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_cmd <= n_cmd;
        if (emit) begin
            r_status  <= e_status;
            r_value   <= e_value;
            r_index   <= idx_x[pls_pkg::INDEX_W-1:0];
            r_count_o <= cnt_x[pls_pkg::COUNT_W-1:0];
            r_last    <= e_last;
        end
    end

    assign o_idle        = (r_state == S_IDLE);
    assign o_count       = r_count;
    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_entry_value = r_value;
    assign o_entry_index = r_index;
    assign o_entry_count = r_count_o;
    assign o_last        = r_last;

endmodule

// File: design/positional_list_store.sv
// Top level of the positional list store: front end, command queue, back end.
// Depends on pls_pkg, pls_front, pls_queue and pls_back.
//
//   channel   direction  handshake            payload
//   request   in         i_valid / o_stall    i_req_type, i_position, i_value
//   result    out        o_valid / i_stall    o_status, o_entry_value, o_entry_index,
//                                             o_entry_count, o_last
//
// Requests are taken one per cycle until the 4-entry command queue fills.
// Back end, one command at a time, with one write and one read port on the entry memory:
// update, rejected request or empty dump go straight to finish; insert shifts entries at or
// above pos up, delete those above pos down; dump gives one entry per cycle unless stalled.
// Reset clears counts, queue and sequencer; the entry memory is not cleared.
// A stalled result holds the back end; the front end keeps filling the queue.
module positional_list_store #(
    parameter int DEPTH = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [1:0]                         i_req_type,
    input  logic [pls_pkg::POS_W-1:0]          i_position,
    input  logic signed [pls_pkg::VALUE_W-1:0] i_value,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [1:0]                         o_status,
    output logic signed [pls_pkg::VALUE_W-1:0] o_entry_value,
    output logic [pls_pkg::INDEX_W-1:0]        o_entry_index,
    output logic [pls_pkg::COUNT_W-1:0]        o_entry_count,
    output logic                               o_last
);

    localparam int CW = $clog2(DEPTH + 1);

    logic          q_full;
    logic          q_valid;
    logic          q_push;
    logic          q_pop;
    pls_pkg::t_cmd f_cmd;
    pls_pkg::t_cmd q_cmd;
    logic [CW-1:0] front_count;
    logic [CW-1:0] back_count;
    logic          back_idle;

    pls_front #(.DEPTH(DEPTH)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_req_type (i_req_type),
        .i_position (i_position),
        .i_value    (i_value),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_cmd      (f_cmd),
        .o_count    (front_count)
    );

    pls_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (f_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    pls_back #(.DEPTH(DEPTH)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_cmd       (q_cmd),
        .o_q_pop       (q_pop),
        .o_idle        (back_idle),
        .o_count       (back_count),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_entry_value (o_entry_value),
        .o_entry_index (o_entry_index),
        .o_entry_count (o_entry_count),
        .o_last        (o_last)
    );

    assign o_stall = q_full;

`ifndef SYNTH
    a_counts_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!q_valid && back_idle) |-> (front_count == back_count))
        else $error("front and back list counts disagree");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_count <= CW'(DEPTH))
        else $error("list count above depth");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == pls_pkg::ST_EMPTY) |-> (o_last && o_entry_count == '0))
        else $error("empty dump result malformed");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != pls_pkg::ST_OK) |-> (o_entry_value == '0 && o_entry_index == '0))
        else $error("non-entry result carries entry data");
`endif

endmodule
